// ===== rtl/lru_cache_with_victim_buffer_macros.svh =====
// Assertion macros for the LRU cache with victim buffer.
// Included by the modules that carry concurrent assertions.
`ifndef LRU_CACHE_WITH_VICTIM_BUFFER_MACROS_SVH
`define LRU_CACHE_WITH_VICTIM_BUFFER_MACROS_SVH
// Implication checked every clock outside reset.
`define LCV_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);
// Implication whose consequent is checked at the next clock.
`define LCV_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);
`endif

// ===== rtl/lcv_pkg.sv =====
// Shared outcome codes of the LRU cache with victim buffer.
// No dependencies.
`default_nettype none
package lcv_pkg;
   localparam logic [1:0] OUT_HIT   = 2'd0;
   localparam logic [1:0] OUT_FILL  = 2'd1;
   localparam logic [1:0] OUT_SWAP  = 2'd2;
   localparam logic [1:0] OUT_EVICT = 2'd3;
endpackage
`default_nettype wire

// ===== rtl/lcv_ram.sv =====
// Generic simple dual-port synchronous RAM (one write, one read port) with registered read.
// No dependencies.
`default_nettype none
module lcv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/lru_cache_with_victim_buffer.sv =====
// Top level of the LRU cache with victim buffer: sequencer, victim buffer,
// counters. Depends on lcv_pkg, lcv_ram and the assertion macro header.
//
// Each transaction runs as accept (ST_IDLE), set read from RAM (ST_RD),
// then decide and write back (ST_UPD). The set's line RAM and recency RAM
// (one word per set) have a registered read; no new transaction is taken
// until the last one is through. After reset a clearing pass writes every
// set invalid with its reset ranks; req_stall is high during it. The
// 8-entry victim buffer is held in flip-flops and searched in parallel.
// Results sit in an output register; the next transaction is taken once the
// previous result has left or in the cycle it leaves.
`default_nettype none
`include "lru_cache_with_victim_buffer_macros.svh"
module lru_cache_with_victim_buffer
   import lcv_pkg::*;
#(
   parameter int SETS = 64,
   parameter int SET_BITS = 6,
   parameter int OFFSET_BITS = 6,
   parameter int WAYS = 4,
   parameter int VICTIM_ENTRIES = 8,
   parameter int TAG_BITS = 20
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [5:0]  req_set_index,
   input  wire logic [19:0] req_line_tag,
   input  wire logic        req_is_write,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_main_hit,
   output logic [1:0]       rsp_outcome,
   output logic             rsp_dirty_writeback,
   output logic [31:0]      rsp_writeback_address,
   output logic [31:0]      rsp_swap_total,
   output logic [31:0]      rsp_kickout_total
);
   localparam int SA = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WB = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int VB = (VICTIM_ENTRIES > 1) ? $clog2(VICTIM_ENTRIES) : 1;
   localparam int LW = TAG_BITS + 2;              // valid, dirty, tag
   localparam int KW = TAG_BITS + SET_BITS;       // block key
   localparam int KP = KW + OFFSET_BITS;
   localparam int RD = (SETS > 1) ? SETS : 2;

   localparam logic [1:0] ST_CLR = 2'd0, ST_IDLE = 2'd1, ST_RD = 2'd2, ST_UPD = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [SA:0] clr_ff, clr_in;
   logic [SA-1:0] set_ff, set_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic wr_ff, wr_in;

   logic [WAYS*LW-1:0] lines_rd, lines_wr;
   logic [WAYS*WB-1:0] rank_rd, rank_wr, rank_init;
   logic ram_we;
   logic [SA-1:0] ram_wa, ram_ra;

   logic v_val_ff [VICTIM_ENTRIES];
   logic v_dty_ff [VICTIM_ENTRIES];
   logic [KW-1:0] v_key_ff [VICTIM_ENTRIES];
   logic [VB-1:0] v_rank_ff [VICTIM_ENTRIES];
   logic [31:0] swaps_ff, kicks_ff;

   logic out_v_ff;
   logic o_hit_ff, o_wb_ff;
   logic [1:0] o_out_ff;
   logic [31:0] o_addr_ff;

   lcv_ram #(.WIDTH(WAYS*LW), .DEPTH(RD)) u_lines (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(lines_wr),
      .rd_addr(ram_ra), .rd_data(lines_rd));
   lcv_ram #(.WIDTH(WAYS*WB), .DEPTH(RD)) u_ranks (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(rank_wr),
      .rd_addr(ram_ra), .rd_data(rank_rd));

   // accept only when idle and the output register is free or draining this cycle
   assign req_stall = (state_ff != ST_IDLE) || (out_v_ff && rsp_stall);
   wire req_take = req_valid && !req_stall;

   always_comb begin
      for (int w = 0; w < WAYS; w++) rank_init[w*WB +: WB] = WB'(w);
   end

   // decision logic on the set word read from RAM
   logic hit, has_empty, vhit, vfree, wb_now;
   logic [WB-1:0] hw, ew, lw, pick;
   logic [VB-1:0] vhw, vfw, vlw, vpick;
   logic [1:0] outc;
   logic [KW-1:0] want, okey;
   logic odirty, ndirty;
   logic [31:0] waddr;
   logic [KP-1:0] wfull;
   logic [WB-1:0] old_r;
   logic [VB-1:0] old_v;

   always_comb begin
      hit = 1'b0; hw = '0; has_empty = 1'b0; ew = '0; lw = '0;
      for (int w = WAYS-1; w >= 0; w--) begin
         if (lines_rd[w*LW+LW-1] && lines_rd[w*LW +: TAG_BITS] == tag_ff) begin
            hit = 1'b1; hw = WB'(w);
         end
         if (!lines_rd[w*LW+LW-1]) begin
            has_empty = 1'b1; ew = WB'(w);
         end
      end
      for (int w = 1; w < WAYS; w++)
         if (rank_rd[w*WB +: WB] > rank_rd[lw*WB +: WB]) lw = WB'(w);
      want = {tag_ff, SET_BITS'(set_ff)};
      okey = {lines_rd[lw*LW +: TAG_BITS], SET_BITS'(set_ff)};
      odirty = lines_rd[lw*LW+TAG_BITS];
      vhit = 1'b0; vhw = '0; vfree = 1'b0; vfw = '0; vlw = '0;
      for (int v = VICTIM_ENTRIES-1; v >= 0; v--) begin
         if (v_val_ff[v] && v_key_ff[v] == want) begin
            vhit = 1'b1; vhw = VB'(v);
         end
         if (!v_val_ff[v]) begin
            vfree = 1'b1; vfw = VB'(v);
         end
      end
      for (int v = 1; v < VICTIM_ENTRIES; v++)
         if (v_rank_ff[v] > v_rank_ff[vlw]) vlw = VB'(v);
      if (hit) outc = OUT_HIT;
      else if (has_empty) outc = OUT_FILL;
      else if (vhit) outc = OUT_SWAP;
      else outc = OUT_EVICT;
      pick = hit ? hw : (has_empty ? ew : lw);
      vpick = vhit ? vhw : (vfree ? vfw : vlw);
      wb_now = (outc == OUT_EVICT) && !vfree && v_dty_ff[vlw];
      wfull = {v_key_ff[vlw], OFFSET_BITS'(0)};
      waddr = wb_now ? 32'(wfull) : 32'd0;
      case (outc)
         OUT_HIT:  ndirty = lines_rd[hw*LW+TAG_BITS] | wr_ff;
         OUT_SWAP: ndirty = v_dty_ff[vhw] | wr_ff;
         default:  ndirty = wr_ff;
      endcase
      lines_wr = lines_rd;
      lines_wr[pick*LW +: LW] = {1'b1, ndirty, tag_ff};
      old_r = rank_rd[pick*WB +: WB];
      rank_wr = rank_rd;
      for (int w = 0; w < WAYS; w++)
         if (rank_rd[w*WB +: WB] < old_r) rank_wr[w*WB +: WB] = rank_rd[w*WB +: WB] + 1'b1;
      rank_wr[pick*WB +: WB] = '0;
      old_v = v_rank_ff[vpick];
      if (state_ff == ST_CLR) begin
         lines_wr = '0; rank_wr = rank_init;
      end
   end

   assign ram_we = (state_ff == ST_CLR) || (state_ff == ST_UPD);
   assign ram_wa = (state_ff == ST_CLR) ? clr_ff[SA-1:0] : set_ff;
   assign ram_ra = set_in;

   always_comb begin
      state_in = state_ff; clr_in = clr_ff;
      set_in = set_ff; tag_in = tag_ff; wr_in = wr_ff;
      case (state_ff)
         ST_CLR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (SA+1)'(SETS-1)) state_in = ST_IDLE;
         end
         ST_IDLE: if (req_take) begin
            state_in = ST_RD;
            set_in = SA'(32'(req_set_index) % SETS);
            tag_in = TAG_BITS'(req_line_tag);
            wr_in = req_is_write;
         end
         ST_RD: state_in = ST_UPD;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      set_ff <= set_in; tag_ff <= tag_in; wr_ff <= wr_in;
      if (state_ff == ST_UPD) begin
         o_hit_ff <= hit; o_out_ff <= outc; o_wb_ff <= wb_now; o_addr_ff <= waddr;
      end
      if (reset) begin
         state_ff <= ST_CLR; clr_ff <= '0; out_v_ff <= 1'b0;
         swaps_ff <= '0; kicks_ff <= '0;
         for (int v = 0; v < VICTIM_ENTRIES; v++) begin
            v_val_ff[v] <= 1'b0; v_rank_ff[v] <= VB'(v);
         end
      end else begin
         state_ff <= state_in; clr_ff <= clr_in;
         if (state_ff == ST_UPD) out_v_ff <= 1'b1;
         else if (!rsp_stall) out_v_ff <= 1'b0;
         // victim buffer is touched only when the set was full and missed
         if (state_ff == ST_UPD && !hit && !has_empty) begin
            if (vhit) swaps_ff <= swaps_ff + 1'b1;
            else if (!vfree) kicks_ff <= kicks_ff + 1'b1;
            for (int v = 0; v < VICTIM_ENTRIES; v++)
               if (v_rank_ff[v] < old_v) v_rank_ff[v] <= v_rank_ff[v] + 1'b1;
            v_rank_ff[vpick] <= '0;
            v_val_ff[vpick] <= 1'b1;
         end
      end
      if (!reset && state_ff == ST_UPD && !hit && !has_empty) begin
         v_dty_ff[vpick] <= odirty; v_key_ff[vpick] <= okey;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_main_hit = o_hit_ff;
   assign rsp_outcome = o_out_ff;
   assign rsp_dirty_writeback = o_wb_ff;
   assign rsp_writeback_address = o_addr_ff;
   assign rsp_swap_total = swaps_ff;
   assign rsp_kickout_total = kicks_ff;

   `LCV_ASSERT_IMP(a_no_take_busy, clock, reset, state_ff != ST_IDLE, req_stall, "accept while busy")
   `LCV_ASSERT_NEXT(a_upd_result, clock, reset, state_ff == ST_UPD, rsp_valid, "result lost")
   `LCV_ASSERT_IMP(a_wb_evict, clock, reset, rsp_valid && rsp_dirty_writeback, rsp_outcome == OUT_EVICT, "writeback without eviction")
endmodule
`default_nettype wire

// ===== bench/lru_cache_with_victim_buffer_checker.sv =====
// Checker for the LRU cache with victim buffer: watches both channels, keeps
// its own cache model and compares each result. Depends on lcv_pkg.
`default_nettype none
module lru_cache_with_victim_buffer_checker
   import lcv_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [5:0]  req_set_index,
   input  wire logic [19:0] req_line_tag,
   input  wire logic        req_is_write,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic        rsp_main_hit,
   input  wire logic [1:0]  rsp_outcome,
   input  wire logic        rsp_dirty_writeback,
   input  wire logic [31:0] rsp_writeback_address,
   input  wire logic [31:0] rsp_swap_total,
   input  wire logic [31:0] rsp_kickout_total,
   output int               failures,
   output int               pending
);
   typedef struct packed {
      logic        main_hit;
      logic [1:0]  outcome;
      logic        dirty_wb;
      logic [31:0] wb_addr;
      logic [31:0] swaps;
      logic [31:0] kicks;
   } access_result_type;

   typedef struct packed {
      logic        valid;
      logic        dirty;
      logic [25:0] key;
   } line_type;

   line_type          ways_m [64][4];
   logic [1:0]        way_rank [64][4];
   line_type          victims_m [8];
   logic [2:0]        victim_rank [8];
   logic [31:0]       swap_count, kick_count;
   access_result_type expected_results [$];

   assign pending = expected_results.size();

   function automatic void promote_way(logic [5:0] set, int w);
      logic [1:0] old;
      old = way_rank[set][w];
      for (int i = 0; i < 4; i++)
         if (way_rank[set][i] < old) way_rank[set][i]++;
      way_rank[set][w] = 0;
   endfunction

   function automatic access_result_type access_cache(logic [5:0] set, logic [19:0] tag,
                                                      logic wr);
      access_result_type r;
      int w, v, lru;
      logic [25:0] want, out_key;
      logic out_dirty;
      r = '0;
      w = -1;
      for (int i = 0; i < 4; i++)
         if (w < 0 && ways_m[set][i].valid && ways_m[set][i].key[19:0] == tag) w = i;
      if (w >= 0) begin
         r.main_hit = 1'b1;
         r.outcome = OUT_HIT;
         if (wr) ways_m[set][w].dirty = 1'b1;
         promote_way(set, w);
      end else begin
         for (int i = 0; i < 4; i++)
            if (w < 0 && !ways_m[set][i].valid) w = i;
         if (w >= 0) begin
            r.outcome = OUT_FILL;
            ways_m[set][w] = '{1'b1, wr, {6'd0, tag}};
            promote_way(set, w);
         end else begin
            lru = 0;
            for (int i = 1; i < 4; i++)
               if (way_rank[set][i] > way_rank[set][lru]) lru = i;
            want = {tag, set};
            out_key = {ways_m[set][lru].key[19:0], set};
            out_dirty = ways_m[set][lru].dirty;
            v = -1;
            for (int i = 0; i < 8; i++)
               if (v < 0 && victims_m[i].valid && victims_m[i].key == want) v = i;
            if (v >= 0) begin
               r.outcome = OUT_SWAP;
               ways_m[set][lru].dirty = victims_m[v].dirty | wr;
               swap_count++;
            end else begin
               r.outcome = OUT_EVICT;
               for (int i = 0; i < 8; i++)
                  if (v < 0 && !victims_m[i].valid) v = i;
               if (v < 0) begin
                  v = 0;
                  for (int i = 1; i < 8; i++)
                     if (victim_rank[i] > victim_rank[v]) v = i;
                  if (victims_m[v].dirty) begin
                     r.dirty_wb = 1'b1;
                     r.wb_addr = {victims_m[v].key, 6'd0};
                  end
                  kick_count++;
               end
               ways_m[set][lru].dirty = wr;
            end
            victims_m[v] = '{1'b1, out_dirty, out_key};
            // promote the victim entry to MRU
            for (int i = 0; i < 8; i++)
               if (victim_rank[i] < victim_rank[v]) victim_rank[i]++;
            victim_rank[v] = 0;
            ways_m[set][lru].key = {6'd0, tag};
            promote_way(set, lru);
         end
      end
      r.swaps = swap_count;
      r.kicks = kick_count;
      return r;
   endfunction

   always @(posedge clock) begin
      access_result_type e;
      if (reset) begin
         for (int s = 0; s < 64; s++)
            for (int w = 0; w < 4; w++) begin
               ways_m[s][w] = '0;
               way_rank[s][w] = w[1:0];
            end
         for (int v = 0; v < 8; v++) begin
            victims_m[v] = '0;
            victim_rank[v] = v[2:0];
         end
         swap_count = 0;
         kick_count = 0;
         failures <= 0;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result transaction");
               failures <= failures + 1;
            end else begin
               e = expected_results.pop_front();
               if (rsp_main_hit !== e.main_hit ||
                   rsp_outcome !== e.outcome ||
                   rsp_dirty_writeback !== e.dirty_wb ||
                   rsp_writeback_address !== e.wb_addr ||
                   rsp_swap_total !== e.swaps ||
                   rsp_kickout_total !== e.kicks)
                  failures <= failures + 1;
               if (rsp_main_hit !== e.main_hit)
                  $error("main_hit exp %0h got %0h", e.main_hit, rsp_main_hit);
               if (rsp_outcome !== e.outcome)
                  $error("outcome exp %0h got %0h", e.outcome, rsp_outcome);
               if (rsp_dirty_writeback !== e.dirty_wb)
                  $error("dirty_writeback exp %0h got %0h", e.dirty_wb, rsp_dirty_writeback);
               if (rsp_writeback_address !== e.wb_addr)
                  $error("writeback_address exp %0h got %0h", e.wb_addr,
                         rsp_writeback_address);
               if (rsp_swap_total !== e.swaps)
                  $error("swap_total exp %0h got %0h", e.swaps, rsp_swap_total);
               if (rsp_kickout_total !== e.kicks)
                  $error("kickout_total exp %0h got %0h", e.kicks, rsp_kickout_total);
            end
         end
         if (req_valid && !req_stall)
            expected_results.push_back(access_cache(req_set_index, req_line_tag,
                                                    req_is_write));
      end
   end
endmodule
`default_nettype wire

// ===== bench/lru_cache_with_victim_buffer_test.sv =====
// Top of the bench for the LRU cache with victim buffer: clock, reset,
// access stimulus, result stall pattern and verdict. Depends on the block
// and lru_cache_with_victim_buffer_checker.
`default_nettype none
module lru_cache_with_victim_buffer_test;

   logic        clock, reset;
   logic        req_valid, req_stall;
   logic [5:0]  req_set_index;
   logic [19:0] req_line_tag;
   logic        req_is_write;
   logic        rsp_valid, rsp_stall;
   logic        rsp_main_hit;
   logic [1:0]  rsp_outcome;
   logic        rsp_dirty_writeback;
   logic [31:0] rsp_writeback_address, rsp_swap_total, rsp_kickout_total;
   int          failures, pending;
   int          idle_cycles;
   logic        hold_off;   // long receiver stall window

   lru_cache_with_victim_buffer dut (.*);

   lru_cache_with_victim_buffer_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Receiver: random stall pattern, with quiet stretches and one or more long hold-offs.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off)
            rsp_stall <= 1'b1;
         else if ($urandom_range(0, 199) < 60)
            rsp_stall <= 1'b0;     // quiet window mixed with random stalls
         else
            rsp_stall <= ($urandom_range(0, 3) == 0);
      end
   end

   // Watchdog: count cycles with no accepted transaction on either side.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Offer one transaction and hold it until accepted.
   task automatic send_access(logic [5:0] set, logic [19:0] tag, logic wr);
      req_valid <= 1'b1;
      req_set_index <= set;
      req_line_tag <= tag;
      req_is_write <= wr;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid for a random gap after a burst.
   task automatic idle_gap();
      int n;
      n = $urandom_range(1, 6);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   initial begin
      int burst;
      logic [5:0] hot_set;
      logic [19:0] tags [12];
      hold_off = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_set_index = '0;
      req_line_tag = '0;
      req_is_write = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: fill set 0, hit, force victim entries, swap, extremes.
      for (int i = 0; i < 4; i++) send_access(6'd0, 20'(i), 1'b1);   // empty-way fills
      send_access(6'd0, 20'd2, 1'b0);                               // main hit
      send_access(6'd63, 20'hFFFFF, 1'b1);                          // extreme fields
      for (int i = 4; i < 14; i++) send_access(6'd0, 20'(i), i[0]); // displace, fill buffer
      send_access(6'd0, 20'd5, 1'b1);                               // victim swap
      send_access(6'd0, 20'd0, 1'b0);                               // likely evicted: miss
      send_access(6'd63, 20'hFFFFF, 1'b0);                          // hit at extremes
      req_valid <= 1'b0;

      // Pause until every expected result has arrived.
      while (pending != 0) @(posedge clock);

      // Random: mostly a few hot sets with a small tag pool so that hits,
      // swaps and dirty kickouts are frequent; the rest is noise.
      for (int i = 0; i < 12; i++) tags[i] = 20'($urandom);
      hot_set = 6'($urandom);
      for (int n = 0; n < 650;) begin
         burst = $urandom_range(1, 20);
         if (n > 300 && n < 330) begin
            // Hold the receiver off while the sender keeps offering.
            fork
               begin
                  hold_off = 1'b1;
                  repeat (60) @(posedge clock);
                  hold_off = 1'b0;
               end
            join_none
         end
         for (int b = 0; b < burst; b++, n++) begin
            if ($urandom_range(0, 99) < 80)
               send_access($urandom_range(0, 3) == 0 ? 6'($urandom) : hot_set,
                           tags[$urandom_range(0, 11)], 1'($urandom));
            else
               send_access(6'($urandom), 20'($urandom), 1'($urandom));
            if ($urandom_range(0, 49) == 0) hot_set = 6'($urandom);
         end
         if ($urandom_range(0, 3) != 0) idle_gap();
      end
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
`default_nettype wire
